// File: rtl/ppm_pkg.sv
// ----------------------------------------------------------------------------
// ppm_pkg: shared types and constants of the PCM peak-to-peak meter
// Register indexes, payload widths and the operation record that travels
// from the byte front end to the min/max back end.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned LevelW   = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegChannelCount = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSampleWidth  = 2'd1;

  // Channel count codes
  localparam logic [1:0] ChMono   = 2'd1;
  localparam logic [1:0] ChStereo = 2'd2;

  // Reset values of the configuration registers
  localparam logic [1:0] ChannelCountReset = ChStereo;
  localparam logic [1:0] SampleWidthReset  = 2'd1;

  // One classified byte, as handed to the back end
  typedef struct packed {
    logic               complete;     // a full sample is ready
    logic               second_chan;  // sample belongs to the right channel
    logic               mono;         // one channel per frame
    logic signed [15:0] sample;
    logic               last;         // end of buffer: report and clear
    logic               emit;         // a result is produced on last
  } ppm_op_t;

endpackage

// File: rtl/ppm_if.sv
// ----------------------------------------------------------------------------
// ppm interfaces: valid/ready channels of the PCM peak-to-peak meter
// Byte input channel, level result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface ppm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ppm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left_level;
  logic [15:0] right_level;

  modport source (output valid, output left_level, output right_level, input ready);
  modport sink   (input valid, input left_level, input right_level, output ready);
endinterface

interface ppm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [ppm_pkg::CfgIdxW-1:0]  index;
  logic [ppm_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/ppm_front.sv
// ----------------------------------------------------------------------------
// ppm_front: byte front end
// Tracks the byte position in a frame, builds 16-bit samples from the top two
// bytes or one sign-extended byte; classifies each into a back-end operation.
// ----------------------------------------------------------------------------
module ppm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        channel_count_i,
  input  logic [1:0]        sample_width_code_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              op_full_i,
  output logic              op_push_o,
  output ppm_pkg::ppm_op_t  op_o
);
  import ppm_pkg::*;

  logic [2:0] pos_q, pos_d;
  logic [7:0] held_q, held_d;
  logic       cfg_ok, mono, chan, accept;
  logic [2:0] bps, pos_eff, off;
  logic [3:0] flen, pos_inc;

  assign accept     = in_valid_i && !op_full_i;
  assign in_ready_o = !op_full_i;
  assign op_push_o  = accept;

  // Decode the frame layout from the configuration
  assign cfg_ok  = (channel_count_i == ChMono) || (channel_count_i == ChStereo);
  assign mono    = (channel_count_i == ChMono);
  assign bps     = {1'b0, sample_width_code_i} + 3'd1;
  assign flen    = mono ? {1'b0, bps} : {bps, 1'b0};
  assign pos_eff = ({1'b0, pos_q} >= flen) ? 3'd0 : pos_q;
  assign chan    = !mono && (pos_eff >= bps);
  assign off     = chan ? (pos_eff - bps) : pos_eff;
  assign pos_inc = {1'b0, pos_eff} + 4'd1;

  // Classify the byte and advance the frame position
  always_comb begin
    pos_d          = pos_q;
    held_d         = held_q;
    op_o.complete  = 1'b0;
    op_o.second_chan = chan;
    op_o.mono      = mono;
    op_o.sample    = '0;
    op_o.last      = last_byte_i;
    op_o.emit      = last_byte_i && cfg_ok;
    if (cfg_ok) begin
      if (bps == 3'd1) begin
        op_o.sample   = {{8{data_byte_i[7]}}, data_byte_i};
        op_o.complete = 1'b1;
      end else if (off == bps - 3'd2) begin
        held_d = data_byte_i;
      end else if (off == bps - 3'd1) begin
        op_o.sample   = {data_byte_i, held_q};
        op_o.complete = 1'b1;
      end
      pos_d = (pos_inc >= flen) ? 3'd0 : pos_inc[2:0];
    end
    if (last_byte_i) begin
      pos_d  = '0;
      held_d = '0;
    end
  end

  // Hold frame state between transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      held_q <= '0;
    end else if (accept) begin
      pos_q  <= pos_d;
      held_q <= held_d;
    end
  end

endmodule

// File: rtl/ppm_queue.sv
// ----------------------------------------------------------------------------
// ppm_queue: operation queue between front and back end
// Small circular buffer so either side can stall without stopping the other.
// ----------------------------------------------------------------------------
module ppm_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ppm_pkg::ppm_op_t  push_op_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output ppm_pkg::ppm_op_t  head_o
);
  import ppm_pkg::*;

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  ppm_op_t              mem_q [Depth];
  logic [AddrW-1:0]     wptr_q, rptr_q;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= (wptr_q == AddrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == AddrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_op_i;
    end
  end

endmodule

// File: rtl/ppm_back.sv
// ----------------------------------------------------------------------------
// ppm_back: min/max back end
// Updates the per-channel running extremes and loads the level result
// register at the end of a buffer.
// ----------------------------------------------------------------------------
module ppm_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  ppm_pkg::ppm_op_t  head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       left_level_o,
  output logic [15:0]       right_level_o
);
  import ppm_pkg::*;

  logic signed [15:0] lmin_q, lmax_q, rmin_q, rmax_q, pend_q;
  logic signed [15:0] lmin_d, lmax_d, rmin_d, rmax_d, pend_d, lcand;
  logic               out_valid_q, out_valid_d, load;
  logic [15:0]        left_q, right_q, left_d;
  logic               trk_left, trk_right, set_pend;

  // Pop unless a result must wait for a busy output register
  assign pop_o = !empty_i && (!head_i.emit || !out_valid_q || out_ready_i);
  assign load  = pop_o && head_i.emit;

  assign trk_left  = head_i.complete && (head_i.second_chan || head_i.mono);
  assign trk_right = head_i.complete && head_i.second_chan;
  assign set_pend  = head_i.complete && !head_i.second_chan && !head_i.mono;
  assign lcand     = head_i.mono ? head_i.sample : pend_q;

  // Compare and select the new extremes
  always_comb begin
    lmin_d = lmin_q;
    lmax_d = lmax_q;
    rmin_d = rmin_q;
    rmax_d = rmax_q;
    pend_d = set_pend ? head_i.sample : pend_q;
    if (trk_left) begin
      if (lcand < lmin_q) lmin_d = lcand;
      if (lcand > lmax_q) lmax_d = lcand;
    end
    if (trk_right) begin
      if (head_i.sample < rmin_q) rmin_d = head_i.sample;
      if (head_i.sample > rmax_q) rmax_d = head_i.sample;
    end
  end

  assign left_d      = 16'(lmax_d - lmin_d);
  assign out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  // Update running state; clear it at end of buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lmin_q      <= '0;
      lmax_q      <= '0;
      rmin_q      <= '0;
      rmax_q      <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        if (head_i.last) begin
          lmin_q <= '0;
          lmax_q <= '0;
          rmin_q <= '0;
          rmax_q <= '0;
          pend_q <= '0;
        end else begin
          lmin_q <= lmin_d;
          lmax_q <= lmax_d;
          rmin_q <= rmin_d;
          rmax_q <= rmax_d;
          pend_q <= pend_d;
        end
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      left_q  <= left_d;
      right_q <= head_i.mono ? left_d : 16'(rmax_d - rmin_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_level_o  = left_q;
  assign right_level_o = right_q;

endmodule

// File: rtl/pcm_peak_to_peak_meter.sv
// Path: a last byte's result is registered in the operation queue, then in the result register.
// Throughput: one byte per cycle while no result waits at a busy output; the front end,
// the operation queue and the back end each keep that pace, and the queue absorbs output stalls until it fills.
// Reset: asynchronous, active low; clears extremes, frame position, queue and
// result valid, and sets stereo with 16-bit samples.
// ----------------------------------------------------------------------------
// pcm_peak_to_peak_meter: per-channel peak-to-peak level of a PCM buffer
// Bytes are classified by the front end, queued, and folded into running
// minimum and maximum registers by the back end.
// ----------------------------------------------------------------------------
module pcm_peak_to_peak_meter #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ppm_in_if.sink      in_i,
  ppm_out_if.source   out_o,
  ppm_cfg_if.sink     cfg_i
);
  import ppm_pkg::*;

  logic [1:0] channel_count_q, sample_width_q;
  logic       op_full, op_push, op_empty, op_pop;
  ppm_op_t    op_in, op_head;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      channel_count_q <= ChannelCountReset;
      sample_width_q  <= SampleWidthReset;
    end else if (cfg_i.valid) begin
      if (cfg_i.index == RegChannelCount) channel_count_q <= cfg_i.data[1:0];
      if (cfg_i.index == RegSampleWidth)  sample_width_q  <= cfg_i.data[1:0];
    end
  end

  ppm_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .channel_count_i     (channel_count_q),
    .sample_width_code_i (sample_width_q),
    .in_valid_i          (in_i.valid),
    .in_ready_o          (in_i.ready),
    .data_byte_i         (in_i.data_byte),
    .last_byte_i         (in_i.last_byte),
    .op_full_i           (op_full),
    .op_push_o           (op_push),
    .op_o                (op_in)
  );

  ppm_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (op_push),
    .push_op_i (op_in),
    .full_o    (op_full),
    .pop_i     (op_pop),
    .empty_o   (op_empty),
    .head_o    (op_head)
  );

  ppm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (op_empty),
    .head_i        (op_head),
    .pop_o         (op_pop),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .left_level_o  (out_o.left_level),
    .right_level_o (out_o.right_level)
  );

endmodule

// File: rtl/ppm_checker.sv
// ----------------------------------------------------------------------------
// ppm_checker: port-level checks of the PCM peak-to-peak meter
// Watches the byte and result channels of the top level over time.
// ----------------------------------------------------------------------------
module ppm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] left_level_i,
  input logic [15:0] right_level_i
);

  // Hold a result until its transaction completes
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(left_level_i) && $stable(right_level_i))
    else $error("result payload changed while stalled");

  // Input backpressure only comes from a result waiting at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled without a pending result");

  // No result right after reset
  a_reset_idle: assert property (@(posedge clk_i)
    $past(!rst_ni) |-> !out_valid_i)
    else $error("result valid after reset");

endmodule

bind pcm_peak_to_peak_meter ppm_checker u_ppm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .left_level_i  (out_o.left_level),
  .right_level_i (out_o.right_level)
);
